// File: src/svm_pkg.sv
// svm_pkg: shared types, opcode and status codes, and helpers for the stack VM.
// No dependencies; imported by svm_muldiv and stack_vm_execute.
package svm_pkg;

    localparam int unsigned MEM_WORDS  = 4096;
    localparam int unsigned MEM_AW     = $clog2(MEM_WORDS);
    localparam logic [63:0] MEM_BYTES  = 64'(MEM_WORDS) * 64'd8;
    localparam int unsigned TEXT_WORDS = 65536;
    localparam int unsigned PC_W       = $clog2(TEXT_WORDS);

    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_CALL = 6'd3;
    localparam logic [5:0] OP_JZ   = 6'd4;
    localparam logic [5:0] OP_JNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_EXIT = 6'd37;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_EXIT  = 3'd1;
    localparam logic [2:0] ST_UNSUP = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_FAULT = 3'd4;

    typedef struct packed {
        logic [5:0]         opcode;
        logic signed [63:0] operand;
    } in_t;

    typedef struct packed {
        logic [PC_W-1:0]    next_pc;
        logic signed [63:0] acc_value;
        logic signed [63:0] exit_value;
        logic [2:0]         run_status;
    } out_t;

    typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_kind_t;

    typedef struct packed {
        logic       start;
        md_kind_t   kind;
        logic [63:0] a;
        logic [63:0] b;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } md_rsp_t;

    function automatic logic word_ok(input logic [63:0] a);
        return (a[2:0] == 3'd0) && (a < MEM_BYTES);
    endfunction

    function automatic logic [63:0] sext8(input logic [7:0] b);
        return {{56{b[7]}}, b};
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // combinational ALU ops: logic, compares, shifts, add, sub
    function automatic logic [63:0] alu_simple(input logic [5:0] op,
                                               input logic [63:0] a,
                                               input logic [63:0] b);
        logic big;
        logic [63:0] r;
        big = (b[63:6] != 58'd0);
        unique case (op)
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_AND:  r = a & b;
            OP_EQ:   r = {63'd0, a == b};
            OP_NE:   r = {63'd0, a != b};
            OP_LT:   r = {63'd0, $signed(a) < $signed(b)};
            OP_GT:   r = {63'd0, $signed(b) < $signed(a)};
            OP_LE:   r = {63'd0, !($signed(b) < $signed(a))};
            OP_GE:   r = {63'd0, !($signed(a) < $signed(b))};
            OP_SHL:  r = big ? 64'd0 : (a << b[5:0]);
            OP_SHR:  r = big ? {64{a[63]}} : 64'($signed(a) >>> b[5:0]);
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

endpackage

// File: src/svm_muldiv.sv
// svm_muldiv: iterative 64-bit multiply / unsigned divide, one bit per cycle.
// Depends on svm_pkg. One shared 65-bit adder serves both operations.
module svm_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  svm_pkg::md_req_t req,
    output svm_pkg::md_rsp_t rsp
);
    import svm_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    md_kind_t    kind_reg;
    logic [63:0] x_reg;    // multiplicand / dividend-quotient
    logic [63:0] y_reg;    // multiplier / divisor
    logic [63:0] acc_reg;  // product / remainder
    logic        done_reg;

    logic        is_div;
    logic [64:0] rem_sh;
    logic [64:0] op_a;
    logic [64:0] op_b;
    logic [65:0] sum;

    assign is_div = (kind_reg != MD_MUL);
    assign rem_sh = {acc_reg, x_reg[63]};
    assign op_a   = is_div ? rem_sh : {1'b0, acc_reg};
    assign op_b   = is_div ? ~{1'b0, y_reg} : {1'b0, x_reg};
    assign sum    = {1'b0, op_a} + {1'b0, op_b} + {65'd0, is_div};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd63;
                kind_reg <= req.kind;
                x_reg    <= req.a;
                y_reg    <= req.b;
                acc_reg  <= 64'd0;
            end
            else if (busy_reg)
            begin
                if (is_div)
                begin
                    // carry out set: shifted remainder >= divisor
                    if (sum[65])
                    begin
                        acc_reg <= sum[63:0];
                        x_reg   <= {x_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= rem_sh[63:0];
                        x_reg   <= {x_reg[62:0], 1'b0};
                    end
                end
                else
                begin
                    if (y_reg[0])
                        acc_reg <= sum[63:0];
                    x_reg <= {x_reg[62:0], 1'b0};
                    y_reg <= {1'b0, y_reg[63:1]};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (kind_reg == MD_DIV) ? x_reg : acc_reg;

endmodule

// File: src/stack_vm_execute.sv
// stack_vm_execute: top level of the accumulator/stack bytecode execute unit.
// Depends on svm_pkg and svm_muldiv; holds the data memory and sequencer.

// One request carries an opcode and the word after it; the block runs that
// instruction against its own accumulator, pc, stack and frame pointers and a
// 4096-word data memory with one port, and returns one result (next pc,
// accumulator, exit value, status). In stall stays high while an instruction
// runs. Register-only instructions use the execute and finish states; a
// memory read adds read and read-wait states, a write the write state (LEV
// and SC read twice). MUL, DIV and MOD run on a shared one-bit-per-cycle
// multiply/divide unit. Once halted (exit, bad opcode, divide by zero, fault)
// every further request just repeats the halting result until reset. The
// start_pc register may only be written while idle; it loads the pc at once.
module stack_vm_execute (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  svm_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output svm_pkg::out_t  out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data
);
    import svm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RD, S_RDW, S_WR, S_MD, S_FIN} state_t;

    state_t          state_reg;
    logic [5:0]      op_reg;
    logic [63:0]     opd_reg;
    logic [63:0]     acc_reg, sp_reg, fp_reg;
    logic [PC_W-1:0] pc_reg;
    logic            halted_reg;
    logic [2:0]      held_st_reg;
    logic [63:0]     held_ex_reg;

    // pending updates of the running instruction
    logic [63:0]     nacc_reg, nsp_reg, nbp_reg;
    logic [PC_W-1:0] npc_reg;
    logic [2:0]      st_reg;
    logic [63:0]     ex_reg;
    logic [63:0]     addr_reg, wdata_reg, v_reg;
    logic            phase_reg;
    logic            neg_reg;

    logic            out_valid_reg;
    out_t            out_reg;

    // data memory
    logic [63:0]     mem [MEM_WORDS];
    logic [63:0]     rdata_reg;

    md_req_t         md_req;
    md_rsp_t         md_rsp;

    logic            in_accept;
    logic            out_free;
    logic [PC_W-1:0] npc1, npc2;
    logic            opd_ok;
    logic [63:0]     opd_x8;
    logic [63:0]     sp_dec;
    logic [63:0]     r;
    logic            r_ok;
    logic [63:0]     md_res;
    logic [63:0]     merged;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign npc1   = pc_reg + PC_W'(1);
    assign npc2   = pc_reg + PC_W'(2);
    assign opd_ok = (opd_reg[63:PC_W] == '0);
    assign opd_x8 = {opd_reg[60:0], 3'b000};
    assign sp_dec = sp_reg - 64'd8;
    assign r      = rdata_reg;
    assign r_ok   = (r[63:PC_W] == '0);
    assign md_res = neg_reg ? (64'd0 - md_rsp.result) : md_rsp.result;

    // SC: replace one byte of the fetched word
    always_comb
    begin
        merged = r;
        merged[{addr_reg[2:0], 3'b000} +: 8] = acc_reg[7:0];
    end

    // start the shared unit when the stack operand of MUL/DIV/MOD arrives (DIV/MOD only for a nonzero divisor)
    always_comb
    begin
        md_req.start = 1'b0;
        md_req.kind  = MD_MUL;
        md_req.a     = r;
        md_req.b     = acc_reg;
        if (state_reg == S_RDW)
        begin
            if (op_reg == OP_MUL)
                md_req.start = 1'b1;
            else if ((op_reg == OP_DIV || op_reg == OP_MOD) && acc_reg != 64'd0)
                md_req.start = 1'b1;
            if (op_reg == OP_DIV)
                md_req.kind = MD_DIV;
            else if (op_reg == OP_MOD)
                md_req.kind = MD_MOD;
            if (op_reg != OP_MUL)
            begin
                md_req.a = mag(r);
                md_req.b = mag(acc_reg);
            end
        end
    end

    svm_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
            rdata_reg <= mem[addr_reg[MEM_AW+2:3]];
        if (state_reg == S_WR)
            mem[addr_reg[MEM_AW+2:3]] <= wdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= 64'd0;
            pc_reg        <= '0;
            sp_reg        <= MEM_BYTES;
            fp_reg        <= MEM_BYTES;
            halted_reg    <= 1'b0;
            held_st_reg   <= ST_RUN;
            held_ex_reg   <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a result taken in the finishing cycle is replaced there
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
                pc_reg <= PC_W'(cfg_data);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg    <= in_data.opcode;
                        opd_reg   <= in_data.operand;
                        nacc_reg  <= acc_reg;
                        nsp_reg   <= sp_reg;
                        nbp_reg   <= fp_reg;
                        npc_reg   <= npc1;
                        st_reg    <= ST_RUN;
                        ex_reg    <= 64'd0;
                        phase_reg <= 1'b0;
                        neg_reg   <= 1'b0;
                        state_reg <= halted_reg ? S_FIN : S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    state_reg <= S_FIN;
                    unique case (op_reg)
                        OP_LEA:
                        begin
                            nacc_reg <= fp_reg + opd_x8;
                            npc_reg  <= npc2;
                        end
                        OP_IMM:
                        begin
                            nacc_reg <= opd_reg;
                            npc_reg  <= npc2;
                        end
                        OP_JMP:
                        begin
                            npc_reg <= opd_reg[PC_W-1:0];
                            if (!opd_ok)
                                st_reg <= ST_FAULT;
                        end
                        OP_CALL:
                        begin
                            if (opd_ok && word_ok(sp_dec))
                            begin
                                addr_reg  <= sp_dec;
                                wdata_reg <= 64'(npc2);
                                nsp_reg   <= sp_dec;
                                npc_reg   <= opd_reg[PC_W-1:0];
                                state_reg <= S_WR;
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        OP_JZ, OP_JNZ:
                        begin
                            if ((acc_reg == 64'd0) == (op_reg == OP_JZ))
                            begin
                                npc_reg <= opd_reg[PC_W-1:0];
                                if (!opd_ok)
                                    st_reg <= ST_FAULT;
                            end
                            else
                                npc_reg <= npc2;
                        end
                        OP_ENT:
                        begin
                            if (word_ok(sp_dec))
                            begin
                                addr_reg  <= sp_dec;
                                wdata_reg <= fp_reg;
                                nbp_reg   <= sp_dec;
                                nsp_reg   <= sp_dec - opd_x8;
                                npc_reg   <= npc2;
                                state_reg <= S_WR;
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        OP_ADJ:
                        begin
                            nsp_reg <= sp_reg + opd_x8;
                            npc_reg <= npc2;
                        end
                        OP_LEV:
                        begin
                            if (word_ok(fp_reg) && fp_reg < MEM_BYTES - 64'd8)
                            begin
                                addr_reg  <= fp_reg;
                                state_reg <= S_RD;
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        OP_LI:
                        begin
                            if (word_ok(acc_reg))
                            begin
                                addr_reg  <= acc_reg;
                                state_reg <= S_RD;
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        OP_LC:
                        begin
                            if (acc_reg < MEM_BYTES)
                            begin
                                addr_reg  <= acc_reg;
                                state_reg <= S_RD;
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        OP_PUSH:
                        begin
                            if (word_ok(sp_dec))
                            begin
                                addr_reg  <= sp_dec;
                                wdata_reg <= acc_reg;
                                nsp_reg   <= sp_dec;
                                state_reg <= S_WR;
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        OP_SI, OP_SC, OP_EXIT, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE,
                        OP_LT, OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB,
                        OP_MUL, OP_DIV, OP_MOD:
                        begin
                            // pop the stack operand first
                            nsp_reg <= sp_reg + 64'd8;
                            if (word_ok(sp_reg))
                            begin
                                addr_reg  <= sp_reg;
                                state_reg <= S_RD;
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        default:
                            st_reg <= ST_UNSUP;
                    endcase
                end

                S_RD:
                    state_reg <= S_RDW;

                S_RDW:
                begin
                    state_reg <= S_FIN;
                    priority case (op_reg)
                        OP_LEV:
                        begin
                            if (!phase_reg)
                            begin
                                v_reg     <= r;
                                addr_reg  <= fp_reg + 64'd8;
                                phase_reg <= 1'b1;
                                state_reg <= S_RD;
                            end
                            else if (r_ok)
                            begin
                                nbp_reg <= v_reg;
                                nsp_reg <= fp_reg + 64'd16;
                                npc_reg <= r[PC_W-1:0];
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        OP_LI:
                            nacc_reg <= r;
                        OP_LC:
                            nacc_reg <= sext8(r[{addr_reg[2:0], 3'b000} +: 8]);
                        OP_SI:
                        begin
                            if (word_ok(r))
                            begin
                                addr_reg  <= r;
                                wdata_reg <= acc_reg;
                                state_reg <= S_WR;
                            end
                            else
                                st_reg <= ST_FAULT;
                        end
                        OP_SC:
                        begin
                            if (!phase_reg)
                            begin
                                if (r < MEM_BYTES)
                                begin
                                    addr_reg  <= r;
                                    phase_reg <= 1'b1;
                                    state_reg <= S_RD;
                                end
                                else
                                    st_reg <= ST_FAULT;
                            end
                            else
                            begin
                                wdata_reg <= merged;
                                nacc_reg  <= sext8(acc_reg[7:0]);
                                state_reg <= S_WR;
                            end
                        end
                        OP_EXIT:
                        begin
                            st_reg <= ST_EXIT;
                            ex_reg <= r;
                        end
                        OP_MUL:
                            state_reg <= S_MD;
                        OP_DIV, OP_MOD:
                        begin
                            if (acc_reg == 64'd0)
                                st_reg <= ST_DIVZ;
                            else
                                state_reg <= S_MD;
                            neg_reg <= (op_reg == OP_DIV) ? (r[63] ^ acc_reg[63]) : r[63];
                        end
                        default:
                            nacc_reg <= alu_simple(op_reg, r, acc_reg);
                    endcase
                end

                S_WR:
                    state_reg <= S_FIN;

                S_MD:
                begin
                    if (md_rsp.done)
                    begin
                        nacc_reg  <= md_res;
                        state_reg <= S_FIN;
                    end
                end

                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (halted_reg)
                        begin
                            out_reg.next_pc    <= pc_reg;
                            out_reg.acc_value  <= acc_reg;
                            out_reg.exit_value <= held_ex_reg;
                            out_reg.run_status <= held_st_reg;
                        end
                        else if (st_reg == ST_RUN)
                        begin
                            acc_reg <= nacc_reg;
                            sp_reg  <= nsp_reg;
                            fp_reg  <= nbp_reg;
                            pc_reg  <= npc_reg;
                            out_reg.next_pc    <= npc_reg;
                            out_reg.acc_value  <= nacc_reg;
                            out_reg.exit_value <= 64'd0;
                            out_reg.run_status <= ST_RUN;
                        end
                        else
                        begin
                            // halting step: state untouched, status latched
                            halted_reg  <= 1'b1;
                            held_st_reg <= st_reg;
                            held_ex_reg <= ex_reg;
                            out_reg.next_pc    <= pc_reg;
                            out_reg.acc_value  <= acc_reg;
                            out_reg.exit_value <= ex_reg;
                            out_reg.run_status <= st_reg;
                        end
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // accepted request keeps the input side busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input not stalled after accept");

    // shared unit only finishes while the sequencer waits on it
    a_md_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == S_MD)
        else $error("muldiv done outside wait state");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    // status code stays within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.run_status <= ST_FAULT)
        else $error("bad run status");

endmodule
